@@ design/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// Free list allocator package
// Shared constants, codes and the command and status structures that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  // Slot space and link word layout
  localparam int SLOT_W     = 12;
  localparam int SLOT_SPACE = 4096;
  localparam int LINK_W     = SLOT_W + 1;
  localparam int COUNT_W    = 13;
  localparam int IPP_W      = 9;
  localparam int ISZ_W      = 13;
  localparam int OFFSET_W   = 24;
  localparam int STATUS_W   = 2;
  localparam int PAGES_W    = 5;

  // Default sizing of the pool
  localparam int MAX_PAGES_DEF          = 16;
  localparam int MAX_ITEMS_PER_PAGE_DEF = 256;

  // Reset values of the configuration registers
  localparam logic [IPP_W-1:0] IPP_RESET = 9'd64;
  localparam logic [ISZ_W-1:0] ISZ_RESET = 13'd8;

  // Configuration register indexes
  localparam logic REG_ITEMS_PER_PAGE = 1'b0;
  localparam logic REG_ITEM_SIZE      = 1'b1;

  // Request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic free_push;
    logic bad_free;
    logic oom;
    logic fill_start;
    logic fill_step;
    logic read_issue;
    logic pop;
    logic load_out;
  } fbfl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_free;
    logic free_bad;
    logic head_valid;
    logic page_fits;
    logic fill_last;
    logic out_free;
  } fbfl_sts_t;

endpackage

@@ design/fbfl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM with separate write and read ports
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage array with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/fbfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Free list allocator controller
// Sequences one request at a time: decode, page build, link read, result.
// ----------------------------------------------------------------------------
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fbfl_sts_t sts,
  output fbfl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_free) begin
          if (sts.free_bad) begin
            cmd.bad_free = 1'b1;
          end else begin
            cmd.free_push = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (sts.head_valid) begin
          cmd.read_issue = 1'b1;
          state_nxt      = ST_READ;
        end else if (sts.page_fits) begin
          cmd.fill_start = 1'b1;
          state_nxt      = ST_FILL;
        end else begin
          cmd.oom   = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_READ: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/fbfl_dp.sv @@
// ----------------------------------------------------------------------------
// Free list allocator datapath
// Head pointer, page bookkeeping, link memory access and the result register.
// ----------------------------------------------------------------------------
module fbfl_dp
  import fbfl_pkg::*;
#(
  parameter int MAX_PAGES          = MAX_PAGES_DEF,
  parameter int MAX_ITEMS_PER_PAGE = MAX_ITEMS_PER_PAGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fbfl_cmd_t           cmd,
  output fbfl_sts_t           sts,
  input  logic                in_command,
  input  logic [SLOT_W-1:0]   in_slot_in,
  input  logic [IPP_W-1:0]    items_per_page,
  input  logic [ISZ_W-1:0]    item_size,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_slot_out,
  output logic [OFFSET_W-1:0] out_byte_offset,
  output logic [STATUS_W-1:0] out_status,
  output logic [PAGES_W-1:0]  out_pages_in_use
);

  localparam int PCW = $clog2(MAX_PAGES + 1);

  // Request and allocator state
  logic                cmd_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   head_r,  head_nxt;
  logic                hv_r,    hv_nxt;
  logic [PCW-1:0]      page_r,  page_nxt;
  logic [COUNT_W-1:0]  made_r,  made_nxt;
  logic [SLOT_W-1:0]   fill_r,  fill_nxt;
  logic [SLOT_W-1:0]   res_slot_r,   res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  // Output register
  logic                out_valid_r,  out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGES_W-1:0]  out_pages_r;

  // Link memory ports
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]   ram_wdata;
  logic [LINK_W-1:0]   ram_rdata;

  logic [COUNT_W-1:0]         page_n;
  logic [COUNT_W-1:0]         room;
  logic [SLOT_W-1:0]          fill_addr;
  logic [SLOT_W-1:0]          fill_next;
  logic [2*SLOT_W:0]          product;
  logic [PCW+PAGES_W-1:0]     pages_ext;

  // Page size, saturated to the supported range.
  always_comb begin
    if (items_per_page == '0) begin
      page_n = COUNT_W'(1);
    end else if ({{(COUNT_W-IPP_W){1'b0}}, items_per_page} > COUNT_W'(MAX_ITEMS_PER_PAGE)) begin
      page_n = COUNT_W'(MAX_ITEMS_PER_PAGE);
    end else begin
      page_n = {{(COUNT_W-IPP_W){1'b0}}, items_per_page};
    end
  end

  assign room      = COUNT_W'(SLOT_SPACE) - made_r;
  assign fill_addr = made_r[SLOT_W-1:0] + fill_r;
  assign fill_next = fill_addr + SLOT_W'(1);

  // Status towards the controller.
  always_comb begin
    sts.is_free    = (cmd_r == CMD_FREE);
    sts.free_bad   = ({1'b0, slot_r} >= made_r);
    sts.head_valid = hv_r;
    sts.page_fits  = (page_r < PCW'(MAX_PAGES)) && !made_r[COUNT_W-1] && (page_n <= room);
    sts.fill_last  = ({1'b0, fill_r} == (page_n - COUNT_W'(1)));
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Link memory writes: a pushed slot, or one link of a new page.
  always_comb begin
    ram_we    = cmd.free_push || cmd.fill_step;
    ram_waddr = cmd.free_push ? slot_r : fill_addr;
    if (cmd.free_push) begin
      ram_wdata = {hv_r, head_r};
    end else if (sts.fill_last) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = {1'b1, fill_next};
    end
  end

  fbfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOT_SPACE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read_issue),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Allocator state updates.
  always_comb begin
    head_nxt       = head_r;
    hv_nxt         = hv_r;
    page_nxt       = page_r;
    made_nxt       = made_r;
    fill_nxt       = fill_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    if (cmd.free_push) begin
      head_nxt       = slot_r;
      hv_nxt         = 1'b1;
      res_slot_nxt   = slot_r;
      res_status_nxt = STATUS_OK;
    end
    if (cmd.bad_free) begin
      res_slot_nxt   = slot_r;
      res_status_nxt = STATUS_BAD_FREE;
    end
    if (cmd.oom) begin
      res_slot_nxt   = '0;
      res_status_nxt = STATUS_OOM;
    end
    if (cmd.fill_start) begin
      fill_nxt = '0;
    end
    if (cmd.fill_step) begin
      fill_nxt = fill_r + SLOT_W'(1);
      if (sts.fill_last) begin
        head_nxt = made_r[SLOT_W-1:0];
        hv_nxt   = 1'b1;
        made_nxt = made_r + page_n;
        page_nxt = page_r + PCW'(1);
      end
    end
    if (cmd.pop) begin
      res_slot_nxt   = head_r;
      res_status_nxt = STATUS_OK;
      head_nxt       = ram_rdata[SLOT_W-1:0];
      hv_nxt         = ram_rdata[LINK_W-1];
    end
  end

  // Offset of the finished slot, formed as the result is registered.
  assign product   = {{(SLOT_W+1){1'b0}}, res_slot_r} * {{(2*SLOT_W+1-ISZ_W){1'b0}}, item_size};
  assign pages_ext = {{PAGES_W{1'b0}}, page_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      hv_r        <= 1'b0;
      page_r      <= '0;
      made_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      hv_r        <= hv_nxt;
      page_r      <= page_nxt;
      made_r      <= made_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r  <= in_command;
      slot_r <= in_slot_in;
    end
    fill_r       <= fill_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load_out) begin
      out_slot_r   <= res_slot_r;
      out_offset_r <= (res_status_r == STATUS_OK) ? product[OFFSET_W-1:0] : '0;
      out_status_r <= res_status_r;
      out_pages_r  <= pages_ext[PAGES_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_out     = out_slot_r;
  assign out_byte_offset  = out_offset_r;
  assign out_status       = out_status_r;
  assign out_pages_in_use = out_pages_r;

endmodule

@@ design/fixed_block_free_list_allocator.sv @@
// Sequencing: a free's result is registered through the EXEC and DONE states
// after its request beat is accepted; an alloc from a non-empty list also
// passes READ for the link read, and one that builds a new page first runs
// through FILL, writing the page's links, and back to EXEC. One request at a
// time; a result still waiting to be taken holds the next one in its last step.
// Reset (synchronous, rst_n low): empty free list, no pages, default config.
// ----------------------------------------------------------------------------
// Fixed block free list allocator
// Pops and pushes slots on a linked free list, growing the pool by pages.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_PAGES          = MAX_PAGES_DEF,
  parameter int MAX_ITEMS_PER_PAGE = MAX_ITEMS_PER_PAGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [SLOT_W-1:0]   in_slot_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   out_slot_out,
  output logic [OFFSET_W-1:0] out_byte_offset,
  output logic [STATUS_W-1:0] out_status,
  output logic [PAGES_W-1:0]  out_pages_in_use,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [IPP_W-1:0] ipp_r, ipp_nxt;
  logic [ISZ_W-1:0] isz_r, isz_nxt;
  logic             cfg_wr;
  fbfl_cmd_t        cmd;
  fbfl_sts_t        sts;

  // Configuration registers behind the APB port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    ipp_nxt = ipp_r;
    isz_nxt = isz_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_ITEMS_PER_PAGE: ipp_nxt = pwdata[IPP_W-1:0];
        REG_ITEM_SIZE:      isz_nxt = pwdata[ISZ_W-1:0];
        default:            ipp_nxt = ipp_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ITEMS_PER_PAGE: prdata = {{(32-IPP_W){1'b0}}, ipp_r};
      REG_ITEM_SIZE:      prdata = {{(32-ISZ_W){1'b0}}, isz_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipp_r <= IPP_RESET;
      isz_r <= ISZ_RESET;
    end else begin
      ipp_r <= ipp_nxt;
      isz_r <= isz_nxt;
    end
  end

  // Controller and datapath.
  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbfl_dp #(
    .MAX_PAGES          (MAX_PAGES),
    .MAX_ITEMS_PER_PAGE (MAX_ITEMS_PER_PAGE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_slot_in       (in_slot_in),
    .items_per_page   (ipp_r),
    .item_size        (isz_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_out     (out_slot_out),
    .out_byte_offset  (out_byte_offset),
    .out_status       (out_status),
    .out_pages_in_use (out_pages_in_use)
  );

`ifndef SYNTHESIS
  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // A new result is only registered out of the controller's final step.
  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in progress");

  // Out of memory reports a null slot and no offset.
  a_oom_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_OOM |-> out_slot_out == '0 && out_byte_offset == '0)
    else $error("out of memory result carries a slot");

  // A rejected free carries no offset.
  a_bad_free_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_BAD_FREE |-> out_byte_offset == '0)
    else $error("rejected free carries an offset");
`endif

endmodule

@@ dv/alloc_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocator result checker
// Watches the request, result and register ports of the free list allocator,
// keeps its own copy of the pool, and compares every result beat against the
// reply that the copy predicts. Failures are counted and handed upwards.
// ----------------------------------------------------------------------------
module alloc_result_checker
  import fbfl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_command,
  input  logic [SLOT_W-1:0]   in_slot_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SLOT_W-1:0]   out_slot_out,
  input  logic [OFFSET_W-1:0] out_byte_offset,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [PAGES_W-1:0]  out_pages_in_use,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fault_count,
  output int                  pending_results
);

  // One predicted reply of the allocator.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic [STATUS_W-1:0] status;
    logic [PAGES_W-1:0]  pages;
  } reply_t;

  // Shadow copy of the pool: link words, list head, growth counters.
  logic [LINK_W-1:0] link_mem [SLOT_SPACE];
  logic [SLOT_W-1:0] head_slot;
  logic              head_valid;
  int unsigned       page_count;
  int unsigned       slots_made;
  logic [IPP_W-1:0]  ipp_reg;
  logic [ISZ_W-1:0]  isz_reg;

  reply_t pending_replies[$];
  reply_t want;

  // Print one line per failure and count it.
  task automatic report_fault(input string what);
    $display("checker: %0t ns: %s", $time, what);
    fault_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned exp_val);
    if (got != exp_val)
      report_fault($sformatf("%s is %0d, predicted %0d", name, got, exp_val));
  endtask

  // Add one page, chaining its slots in ascending order. Returns zero when the
  // page limit is reached or the page would overrun the slot space.
  function automatic bit grow_pool();
    int unsigned n;
    int unsigned k;
    n = ipp_reg;
    if (n < 1) n = 1;
    if (n > MAX_ITEMS_PER_PAGE_DEF) n = MAX_ITEMS_PER_PAGE_DEF;
    if (page_count >= MAX_PAGES_DEF) return 1'b0;
    if (slots_made + n > SLOT_SPACE) return 1'b0;
    for (k = 0; k + 1 < n; k++)
      link_mem[slots_made + k] = {1'b1, SLOT_W'(slots_made + k + 1)};
    link_mem[slots_made + n - 1] = '0;
    head_slot  = SLOT_W'(slots_made);
    head_valid = 1'b1;
    slots_made += n;
    page_count++;
    return 1'b1;
  endfunction

  // Apply one request to the shadow pool and work out its reply.
  function automatic reply_t serve_request(input logic cmd,
                                           input logic [SLOT_W-1:0] slot);
    reply_t            r;
    logic [SLOT_W-1:0] got;
    logic [LINK_W-1:0] link_word;
    logic [31:0]       prod;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (!head_valid && !grow_pool()) begin
        r.status = STATUS_OOM;
      end else begin
        got        = head_slot;
        link_word  = link_mem[got];
        head_slot  = link_word[SLOT_W-1:0];
        head_valid = link_word[SLOT_W];
        prod       = 32'(got) * 32'(isz_reg);
        r.slot     = got;
        r.offset   = prod[OFFSET_W-1:0];
        r.status   = STATUS_OK;
      end
    end else if (32'(slot) >= slots_made) begin
      // A slot that was never created is echoed back and changes nothing.
      r.slot   = slot;
      r.status = STATUS_BAD_FREE;
    end else begin
      link_mem[slot] = head_valid ? {1'b1, head_slot} : '0;
      head_slot  = slot;
      head_valid = 1'b1;
      prod       = 32'(slot) * 32'(isz_reg);
      r.slot     = slot;
      r.offset   = prod[OFFSET_W-1:0];
      r.status   = STATUS_OK;
    end
    r.pages = PAGES_W'(page_count);
    return r;
  endfunction

  // Register writes, request beats and result beats, all taken at the edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (link_mem[k]) link_mem[k] = '0;
      head_slot  = '0;
      head_valid = 1'b0;
      page_count = 0;
      slots_made = 0;
      ipp_reg    = IPP_RESET;
      isz_reg    = ISZ_RESET;
      pending_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ITEM_SIZE) isz_reg = pwdata[ISZ_W-1:0];
        else ipp_reg = pwdata[IPP_W-1:0];
      end

      if (in_valid && in_ready)
        pending_replies.insert(pending_replies.size(),
                               serve_request(in_command, in_slot_in));

      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          report_fault($sformatf("result beat with nothing outstanding, slot %0d",
                                 out_slot_out));
        end else begin
          want = pending_replies.pop_front();
          check_field("slot_out", out_slot_out, want.slot);
          check_field("byte_offset", out_byte_offset, want.offset);
          check_field("status", out_status, want.status);
          check_field("pages_in_use", out_pages_in_use, want.pages);
        end
      end
    end
    pending_results = pending_replies.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Free list allocator testbench
// Drives alloc and free requests and register writes into the allocator,
// with random gaps and back-pressure, while the checker beside it predicts
// and compares every result. Gives the verdict at the end of the run.
// ----------------------------------------------------------------------------
module testbench;
  import fbfl_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 16;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = CMD_ALLOC;
  logic [SLOT_W-1:0]   in_slot_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [OFFSET_W-1:0] out_byte_offset;
  logic [STATUS_W-1:0] out_status;
  logic [PAGES_W-1:0]  out_pages_in_use;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int fault_count;
  int pending_results;
  int gap_pct = 32;
  int stall_pct = 45;
  int quiet_cycles = 0;

  // Slots currently handed out, learnt from result beats, so that frees
  // only return blocks that are really allocated.
  logic [SLOT_W-1:0] held_slots[$];
  logic              sent_cmds[$];
  logic              done_cmd;
  int                hit;
  int                j;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  fixed_block_free_list_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_slot_in(in_slot_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_slot_out(out_slot_out), .out_byte_offset(out_byte_offset),
    .out_status(out_status), .out_pages_in_use(out_pages_in_use),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  alloc_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_slot_in(in_slot_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_slot_out(out_slot_out), .out_byte_offset(out_byte_offset),
    .out_status(out_status), .out_pages_in_use(out_pages_in_use),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fault_count(fault_count), .pending_results(pending_results)
  );

  // Random back-pressure on the result channel.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Track which slots are out, pairing each result beat with its command.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sent_cmds.insert(sent_cmds.size(), in_command);
      if (out_valid && out_ready && sent_cmds.size() > 0) begin
        done_cmd = sent_cmds.pop_front();
        if (out_status == STATUS_OK) begin
          if (done_cmd == CMD_ALLOC) begin
            held_slots.insert(held_slots.size(), out_slot_out);
          end else begin
            hit = -1;
            for (j = 0; j < held_slots.size(); j++)
              if (hit < 0 && held_slots[j] == out_slot_out) hit = j;
            if (hit >= 0) held_slots.delete(hit);
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat or register access ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request beat after a random gap and hold it until taken.
  task automatic push_request(input logic cmd, input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_slot_in <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering requests and wait until every result has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Write both registers back to back over the register port.
  task automatic program_pool(input logic [31:0] ipp, input logic [31:0] isz);
    logic [2:0]  addr_list [2];
    logic [31:0] data_list [2];
    int          k;
    addr_list[0] = {REG_ITEMS_PER_PAGE, 2'b00};
    addr_list[1] = {REG_ITEM_SIZE, 2'b00};
    data_list[0] = ipp;
    data_list[1] = isz;
    for (k = 0; k < 2; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr_list[k];
      pwdata  <= data_list[k];
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random phase: drain, reprogram, then a mix of allocs, frees of held
  // slots and frees of slots that were never created.
  task automatic run_phase(input int gap, input int stall, input logic [31:0] ipp,
                           input logic [31:0] isz, input int count,
                           input int alloc_pct, input int free_pct);
    int                n;
    int                roll;
    int                pick;
    logic [SLOT_W-1:0] victim;
    wait_for_drain();
    program_pool(ipp, isz);
    gap_pct   = gap;
    stall_pct = stall;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        push_request(CMD_ALLOC, SLOT_W'($urandom));
      end else if (roll < alloc_pct + free_pct && held_slots.size() > 0) begin
        pick   = $urandom_range(held_slots.size() - 1);
        victim = held_slots[pick];
        held_slots.delete(pick);
        push_request(CMD_FREE, victim);
      end else begin
        // Well beyond any slot the pool can have created in this run.
        push_request(CMD_FREE, SLOT_W'($urandom_range(4095, 2816)));
      end
    end
  endtask

  initial begin
    logic [SLOT_W-1:0] twice;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed start with the reset configuration. Frees before any page
    // exists, frees just past the last slot and at the top of the space,
    // and allocs whose ignored slot field is at its extremes.
    push_request(CMD_FREE, SLOT_W'(0));
    push_request(CMD_FREE, SLOT_W'(4095));
    push_request(CMD_ALLOC, SLOT_W'(4095));
    push_request(CMD_ALLOC, SLOT_W'(0));
    push_request(CMD_ALLOC, SLOT_W'(2730));
    push_request(CMD_FREE, SLOT_W'(64));
    push_request(CMD_FREE, SLOT_W'(1));
    push_request(CMD_FREE, SLOT_W'(0));
    push_request(CMD_ALLOC, SLOT_W'(1365));
    push_request(CMD_ALLOC, SLOT_W'(0));
    push_request(CMD_FREE, SLOT_W'(2));
    push_request(CMD_FREE, SLOT_W'(2048));
    push_request(CMD_FREE, SLOT_W'(2047));
    push_request(CMD_ALLOC, SLOT_W'(4095));

    // Growth with pages of the largest size: an oversized page setting first,
    // then the exact maximum with a block size above the usual range.
    run_phase(32, 45, 32'd511, 32'd4096, 650, 98, 1);
    run_phase(45, 32, 32'd256, 32'd8191, 650, 98, 1);

    // A zero page setting: drains the list and fills the page limit with
    // single-slot pages, after which allocs run out of memory.
    run_phase(45, 32, 32'd0, 32'($urandom_range(4096, 8)), 250, 90, 5);

    // Churn at full rate with no gaps or back-pressure.
    run_phase(0, 0, 32'd1, 32'd8, 250, 50, 45);

    // A double free goes unnoticed and hands the same slot out again.
    wait_for_drain();
    if (held_slots.size() > 0) begin
      twice = held_slots[0];
      held_slots.delete(0);
      push_request(CMD_FREE, twice);
      push_request(CMD_FREE, twice);
      push_request(CMD_ALLOC, SLOT_W'($urandom));
      push_request(CMD_ALLOC, SLOT_W'($urandom));
      push_request(CMD_ALLOC, SLOT_W'($urandom));
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0 && pending_results == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
